// ===== rtl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, constants and types for the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_W         = 15;

	// one sector is 60 degrees in fractional hue units
	localparam int SECTOR = 60 << HUE_FRAC_BITS;

	// quotient bits: hue magnitude stays below 64 << HUE_FRAC_BITS, saturation
	// below 2^CHANNEL_BITS
	localparam int QUO_W = (CHANNEL_BITS > HUE_FRAC_BITS + 6) ? CHANNEL_BITS :
		HUE_FRAC_BITS + 6;
	localparam int NUM_W = CHANNEL_BITS + QUO_W;

	// signed working width for hue before wrap, holds +/- 6 sectors
	localparam int HSUM_W = HUE_FRAC_BITS + 11;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		sector_t sec;
		logic    neg;
		logic    undef;
		chan_t   mx;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] hue_rem;
		logic [NUM_W-1:0] sat_rem;
		chan_t            hue_den;
		chan_t            sat_den;
		logic [QUO_W-1:0] hue_quo;
		logic [QUO_W-1:0] sat_quo;
		side_t            side;
	} div_t;

endpackage

// ===== rtl/hsv_front.sv =====
// ----------------------------------------------------------------------------
// hsv_front
// Max/min search, sector pick and numerator scaling ahead of the divider.
// ----------------------------------------------------------------------------
module hsv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  hsv_pkg::chan_t red,
	input  hsv_pkg::chan_t green,
	input  hsv_pkg::chan_t blue,
	output logic          out_valid,
	output hsv_pkg::div_t out_div
);
	import hsv_pkg::*;

	chan_t   mx, mn, pa, pb, absd;
	sector_t sec;
	logic    neg;

	logic    valid_s1;
	chan_t   mx_s1, delta_s1, absd_s1;
	logic    neg_s1;
	sector_t sec_s1;

	logic    valid_s2;
	div_t    div_s2;
	div_t    div_d;

	always_comb begin
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		// red wins ties, then green
		if (red >= green && red >= blue) begin
			sec = SEC_RED;
			mx  = red;
			pa  = green;
			pb  = blue;
		end else if (green >= blue) begin
			sec = SEC_GREEN;
			mx  = green;
			pa  = blue;
			pb  = red;
		end else begin
			sec = SEC_BLUE;
			mx  = blue;
			pa  = red;
			pb  = green;
		end
		neg  = pa < pb;
		absd = neg ? pb - pa : pa - pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1    <= mx;
			delta_s1 <= mx - mn;
			absd_s1  <= absd;
			neg_s1   <= neg;
			sec_s1   <= sec;
		end
	end

	always_comb begin
		div_d            = '0;
		div_d.hue_rem    = NUM_W'(absd_s1) * NUM_W'(SECTOR);
		div_d.sat_rem    = (NUM_W'(delta_s1) << CHANNEL_BITS) - NUM_W'(delta_s1);
		div_d.hue_den    = delta_s1;
		div_d.sat_den    = mx_s1;
		div_d.side.sec   = sec_s1;
		div_d.side.neg   = neg_s1;
		div_d.side.undef = (delta_s1 == '0);
		div_d.side.mx    = mx_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) div_s2 <= div_d;
	end

	assign out_valid = valid_s2;
	assign out_div   = div_s2;

endmodule

// ===== rtl/hsv_div.sv =====
// ----------------------------------------------------------------------------
// hsv_div
// Restoring divider pipeline, one quotient bit per stage, hue and saturation
// lanes side by side.
// ----------------------------------------------------------------------------
module hsv_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  hsv_pkg::div_t in_div,
	output logic          out_valid,
	output hsv_pkg::div_t out_div
);
	import hsv_pkg::*;

	logic vld_s [QUO_W];
	div_t stg_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int SH = QUO_W - 1 - k;

		div_t             cur, nxt;
		logic             cur_vld;
		logic [NUM_W-1:0] hue_dsh, sat_dsh;
		logic [NUM_W:0]   hue_try, sat_try;

		if (k == 0) begin : g_first
			assign cur     = in_div;
			assign cur_vld = in_valid;
		end else begin : g_next
			assign cur     = stg_s[k-1];
			assign cur_vld = vld_s[k-1];
		end

		always_comb begin
			nxt     = cur;
			hue_dsh = NUM_W'(cur.hue_den) << SH;
			sat_dsh = NUM_W'(cur.sat_den) << SH;
			hue_try = {1'b0, cur.hue_rem} - {1'b0, hue_dsh};
			sat_try = {1'b0, cur.sat_rem} - {1'b0, sat_dsh};
			if (!hue_try[NUM_W]) begin
				nxt.hue_rem     = hue_try[NUM_W-1:0];
				nxt.hue_quo[SH] = 1'b1;
			end
			if (!sat_try[NUM_W]) begin
				nxt.sat_rem     = sat_try[NUM_W-1:0];
				nxt.sat_quo[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) stg_s[k] <= nxt;
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign out_div   = stg_s[QUO_W-1];

endmodule

// ===== rtl/hsv_back.sv =====
// ----------------------------------------------------------------------------
// hsv_back
// Floor correction, sector offset and wrap of the hue; output registers.
// ----------------------------------------------------------------------------
module hsv_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  hsv_pkg::div_t              in_div,
	output logic                       out_valid,
	output logic [hsv_pkg::HUE_W-1:0]  hue,
	output hsv_pkg::chan_t             saturation,
	output hsv_pkg::chan_t             value,
	output logic                       hue_undefined
);
	import hsv_pkg::*;

	localparam logic signed [HSUM_W-1:0] OFF_GREEN = HSUM_W'(2 * SECTOR);
	localparam logic signed [HSUM_W-1:0] OFF_BLUE  = HSUM_W'(4 * SECTOR);
	localparam logic signed [HSUM_W-1:0] FULL_TURN = HSUM_W'(6 * SECTOR);

	logic signed [HSUM_W-1:0] qext, sq;
	logic                     rem_nz;

	logic                     vld_s1;
	logic signed [HSUM_W-1:0] sq_s1;
	sector_t                  sec_s1;
	logic                     undef_s1;
	chan_t                    mx_s1, sat_s1;

	logic signed [HSUM_W-1:0] off, sum, wrapped;

	logic                     vld_s2;
	logic [HUE_W-1:0]         hue_s2;
	chan_t                    sat_s2, val_s2;
	logic                     undef_s2;

	// negative difference: floor means one further down when not exact
	always_comb begin
		qext   = signed'(HSUM_W'(in_div.hue_quo));
		rem_nz = |in_div.hue_rem;
		if (in_div.side.neg) sq = -(qext + HSUM_W'(rem_nz));
		else sq = qext;
	end

	always_comb begin
		case (sec_s1)
			SEC_GREEN: off = OFF_GREEN;
			SEC_BLUE:  off = OFF_BLUE;
			default:   off = '0;
		endcase
		sum     = sq_s1 + off;
		wrapped = sum[HSUM_W-1] ? sum + FULL_TURN : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1    <= sq;
			sec_s1   <= in_div.side.sec;
			undef_s1 <= in_div.side.undef;
			mx_s1    <= in_div.side.mx;
			// grey and black pixels: quotient lanes hold nothing useful
			sat_s1   <= in_div.side.undef ? '0 : in_div.sat_quo[CHANNEL_BITS-1:0];

			hue_s2   <= undef_s1 ? '0 : HUE_W'(wrapped);
			sat_s2   <= sat_s1;
			val_s2   <= mx_s1;
			undef_s2 <= undef_s1;
		end
	end

	assign out_valid     = vld_s2;
	assign hue           = hue_s2;
	assign saturation    = sat_s2;
	assign value         = val_s2;
	assign hue_undefined = undef_s2;

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV pixel converter, one pixel per clock unless held.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless held and returns one HSV result per
// pixel, in order. 16 register stages sit between the two sides (two front
// stages, one divider stage per quotient bit, two back stages). Throughput is
// one pixel per clock; the whole pipeline holds when the output is valid and
// not taken, so pixel_ready follows hsv_ready combinationally. Hue is in 1/64
// degree, 0..23039; for a grey pixel hue_undefined is set and hue and
// saturation read 0.
module rgb_to_hsv_converter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  hsv_pkg::chan_t            red,
	input  hsv_pkg::chan_t            green,
	input  hsv_pkg::chan_t            blue,
	output logic                      hsv_valid,
	input  logic                      hsv_ready,
	output logic [hsv_pkg::HUE_W-1:0] hue,
	output hsv_pkg::chan_t            saturation,
	output hsv_pkg::chan_t            value,
	output logic                      hue_undefined
);
	import hsv_pkg::*;

	logic adv;
	logic front_valid, div_valid;
	div_t front_div, div_out;

	// a bubble or a taken result lets everything move one stage
	assign adv         = !hsv_valid || hsv_ready;
	assign pixel_ready = adv;

	hsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pixel_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (front_valid),
		.out_div   (front_div)
	);

	hsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (front_valid),
		.in_div    (front_div),
		.out_valid (div_valid),
		.out_div   (div_out)
	);

	hsv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (div_valid),
		.in_div        (div_out),
		.out_valid     (hsv_valid),
		.hue           (hue),
		.saturation    (saturation),
		.value         (value),
		.hue_undefined (hue_undefined)
	);

endmodule
